// ===== hdl/sdspi_pkg.sv =====
// shared types and constants for the sd spi command engine
package sdspi_pkg;

   // field widths
   localparam int IDX_W   = 6;
   localparam int ARG_W   = 32;
   localparam int LEN_W   = 10;
   localparam int BYTE_W  = 8;
   localparam int CNT_W   = 16;
   localparam int STAT_W  = 2;
   localparam int LIMIT_W = 16;

   // limits of the sequence
   localparam logic [LEN_W-1:0] MAX_BLOCK   = LEN_W'(512);
   localparam logic [CNT_W-1:0] RESP_WINDOW = CNT_W'(64);
   localparam logic [LIMIT_W-1:0] TOKEN_WAIT_RESET = LIMIT_W'(20000);

   // opcodes
   localparam logic OP_START = 1'b0;
   localparam logic OP_XFER  = 1'b1;

   // status codes
   localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
   localparam logic [STAT_W-1:0] ST_RESP_TO   = 2'd1;
   localparam logic [STAT_W-1:0] ST_TOKEN_TO  = 2'd2;
   localparam logic [STAT_W-1:0] ST_WR_REJECT = 2'd3;

   // bytes on the wire
   localparam logic [BYTE_W-1:0] BYTE_FILL    = 8'hFF;
   localparam logic [BYTE_W-1:0] BYTE_ZERO    = 8'h00;
   localparam logic [BYTE_W-1:0] BYTE_TOKEN   = 8'hFE;
   localparam logic [BYTE_W-1:0] BYTE_CMD_TAG = 8'h40;
   localparam logic [BYTE_W-1:0] CRC_CMD0     = 8'h95;
   localparam logic [BYTE_W-1:0] CRC_CMD8     = 8'h87;
   localparam logic [3:0]        WR_ACCEPTED  = 4'h5;

   // command numbers with special handling
   localparam logic [IDX_W-1:0] CMD_GO_IDLE   = 6'd0;
   localparam logic [IDX_W-1:0] CMD_SEND_IF   = 6'd8;
   localparam logic [IDX_W-1:0] CMD_READ_OCR  = 6'd58;

   // csr register indexes
   localparam logic REG_TOKEN_WAIT = 1'b0;

   typedef struct packed {
      logic              opcode;
      logic [IDX_W-1:0]  cmd_index;
      logic [ARG_W-1:0]  cmd_arg;
      logic [LEN_W-1:0]  data_len;
      logic              is_read;
      logic [BYTE_W-1:0] rx_byte;
      logic [BYTE_W-1:0] wr_byte;
   } sdspi_req_type;

   typedef struct packed {
      logic [BYTE_W-1:0] tx_byte;
      logic              tx_valid;
      logic              chip_select;
      logic              rd_valid;
      logic [BYTE_W-1:0] rd_byte;
      logic              wr_taken;
      logic              done_res;
      logic [STAT_W-1:0] status;
      logic [ARG_W-1:0]  response;
   } sdspi_rsp_type;

endpackage

// ===== hdl/sdspi_req_if.sv =====
// request channel interface of the sd spi command engine
interface sdspi_req_if import sdspi_pkg::*; ();
   logic          valid;
   logic          ready;
   sdspi_req_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ===== hdl/sdspi_rsp_if.sv =====
// result channel interface of the sd spi command engine
interface sdspi_rsp_if import sdspi_pkg::*; ();
   logic          valid;
   logic          ready;
   sdspi_rsp_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ===== hdl/sd_spi_command_engine_core.sv =====
// SD card SPI mode command sequencer, one byte exchange per request transfer
//
// Each request transfer is either a command start or the report of one finished SPI byte
// exchange; for each the block returns exactly one result that names the next byte to send
// (if any), the chip select level, a read data byte, whether the write byte was consumed, and
// on completion a status and the response. A request can be taken every clock cycle; its
// result is registered at the transfer edge and offered on the result channel from the next
// cycle, or held in the skid register while an earlier result waits. The sequencer state is
// updated in that same cycle, so back-to-back requests see each other's effects. A two-entry
// output buffer (output register plus skid register) lets requests keep flowing while one
// result waits on the result side; req ready drops only when both entries hold results. The
// token_wait_limit register (offset 0, reset 20000) bounds the wait for the read data token
// and should only be written while no command is running.
module sd_spi_command_engine_core import sdspi_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   sdspi_req_if.sink          req,
   sdspi_rsp_if.source        rsp,
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [2:0]         csr_paddr,
   input  logic [31:0]        csr_pwdata,
   output logic [31:0]        csr_prdata,
   output logic               csr_pready
);

   // sequencer phases
   localparam logic [3:0] PH_IDLE   = 4'd0;
   localparam logic [3:0] PH_CMD    = 4'd1;
   localparam logic [3:0] PH_POLL   = 4'd2;
   localparam logic [3:0] PH_WORD   = 4'd3;
   localparam logic [3:0] PH_TOKEN  = 4'd4;
   localparam logic [3:0] PH_RDATA  = 4'd5;
   localparam logic [3:0] PH_RCRC   = 4'd6;
   localparam logic [3:0] PH_TAIL   = 4'd7;
   localparam logic [3:0] PH_WGAP   = 4'd8;
   localparam logic [3:0] PH_WTOKEN = 4'd9;
   localparam logic [3:0] PH_WDATA  = 4'd10;
   localparam logic [3:0] PH_WCRC   = 4'd11;
   localparam logic [3:0] PH_WRESP  = 4'd12;
   localparam logic [3:0] PH_BUSY   = 4'd13;

   logic [3:0]         phase_ff, phase_in;
   logic [IDX_W-1:0]   command_ff, command_in;
   logic [ARG_W-1:0]   argument_ff, argument_in;
   logic [LEN_W-1:0]   length_ff, length_in;
   logic               read_dir_ff, read_dir_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [ARG_W-1:0]   response_ff, response_in;
   logic               select_ff, select_in;
   logic [LIMIT_W-1:0] limit_ff, limit_in;

   logic               head_valid_ff, head_valid_in;
   sdspi_rsp_type      head_ff, head_in;
   logic               skid_valid_ff, skid_valid_in;
   sdspi_rsp_type      skid_ff, skid_in;

   sdspi_rsp_type      result;
   logic               req_xfer;
   logic               rsp_xfer;
   logic               csr_write;
   logic [CNT_W-1:0]   count_inc;
   logic               after_resp;
   logic [BYTE_W-1:0]  rx;

   assign req_xfer  = req.valid & req.ready;
   assign rsp_xfer  = rsp.valid & rsp.ready;
   assign req.ready = ~skid_valid_ff;
   assign rsp.valid = head_valid_ff;
   assign rsp.payload = head_ff;
   assign count_inc = count_ff + CNT_W'(1);
   assign rx        = req.payload.rx_byte;

   // csr port: single token wait register, no wait states
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_prdata = (csr_paddr[2] == REG_TOKEN_WAIT) ? {16'b0, limit_ff} : 32'b0;
   assign limit_in   = (csr_write && csr_paddr[2] == REG_TOKEN_WAIT) ?
                       csr_pwdata[LIMIT_W-1:0] : limit_ff;

   // sequencer next state and result
   always_comb begin
      phase_in    = phase_ff;
      command_in  = command_ff;
      argument_in = argument_ff;
      length_in   = length_ff;
      read_dir_in = read_dir_ff;
      count_in    = count_ff;
      response_in = response_ff;
      select_in   = select_ff;
      after_resp  = 1'b0;
      result      = '0;
      if (req_xfer) begin
         if (req.payload.opcode == OP_START) begin
            command_in  = req.payload.cmd_index;
            argument_in = req.payload.cmd_arg;
            length_in   = (req.payload.data_len > MAX_BLOCK) ? MAX_BLOCK
                                                             : req.payload.data_len;
            read_dir_in = req.payload.is_read;
            response_in = '0;
            select_in   = 1'b1;
            phase_in    = PH_CMD;
            count_in    = CNT_W'(1);
            result.tx_byte  = BYTE_FILL;
            result.tx_valid = 1'b1;
         end else begin
            case (phase_ff)
               PH_CMD: begin
                  result.tx_valid = 1'b1;
                  case (count_ff[2:0])
                     3'd0: result.tx_byte = BYTE_FILL;
                     3'd1: result.tx_byte = BYTE_CMD_TAG | {2'b00, command_ff};
                     3'd2: result.tx_byte = argument_ff[31:24];
                     3'd3: result.tx_byte = argument_ff[23:16];
                     3'd4: result.tx_byte = argument_ff[15:8];
                     3'd5: result.tx_byte = argument_ff[7:0];
                     default: begin
                        if (command_ff == CMD_GO_IDLE)      result.tx_byte = CRC_CMD0;
                        else if (command_ff == CMD_SEND_IF) result.tx_byte = CRC_CMD8;
                        else                                result.tx_byte = BYTE_ZERO;
                     end
                  endcase
                  count_in = count_inc;
                  if (count_inc >= CNT_W'(7)) begin
                     phase_in = PH_POLL;
                     count_in = '0;
                  end
               end
               PH_POLL: begin
                  count_in = count_inc;
                  if (count_inc >= CNT_W'(3) && !rx[7]) begin
                     response_in = {24'b0, rx};
                     if (!rx[2] && (command_ff == CMD_SEND_IF || command_ff == CMD_READ_OCR))
                     begin
                        phase_in = PH_WORD;
                        count_in = '0;
                        result.tx_byte  = BYTE_FILL;
                        result.tx_valid = 1'b1;
                     end else begin
                        after_resp = 1'b1;
                     end
                  end else if (count_inc >= RESP_WINDOW) begin
                     result.done_res = 1'b1;
                     result.status   = ST_RESP_TO;
                  end else begin
                     result.tx_byte  = BYTE_FILL;
                     result.tx_valid = 1'b1;
                  end
               end
               PH_WORD: begin
                  response_in = {response_ff[ARG_W-9:0], rx};
                  count_in    = count_inc;
                  if (count_inc >= CNT_W'(4)) begin
                     after_resp = 1'b1;
                  end else begin
                     result.tx_byte  = BYTE_FILL;
                     result.tx_valid = 1'b1;
                  end
               end
               PH_TOKEN: begin
                  count_in = count_inc;
                  if (rx == BYTE_TOKEN) begin
                     phase_in = PH_RDATA;
                     count_in = '0;
                     result.tx_byte  = BYTE_FILL;
                     result.tx_valid = 1'b1;
                  end else if (count_inc >= limit_ff) begin
                     result.done_res = 1'b1;
                     result.status   = ST_TOKEN_TO;
                  end else begin
                     result.tx_byte  = BYTE_FILL;
                     result.tx_valid = 1'b1;
                  end
               end
               PH_RDATA: begin
                  result.rd_valid = 1'b1;
                  result.rd_byte  = rx;
                  count_in = count_inc;
                  if (count_inc >= {6'b0, length_ff}) begin
                     phase_in = PH_RCRC;
                     count_in = '0;
                  end
                  result.tx_byte  = BYTE_FILL;
                  result.tx_valid = 1'b1;
               end
               PH_RCRC: begin
                  count_in = count_inc;
                  if (count_inc >= CNT_W'(2)) phase_in = PH_TAIL;
                  result.tx_byte  = BYTE_FILL;
                  result.tx_valid = 1'b1;
               end
               PH_TAIL: begin
                  result.done_res = 1'b1;
               end
               PH_WGAP: begin
                  phase_in = PH_WTOKEN;
                  result.tx_byte  = BYTE_TOKEN;
                  result.tx_valid = 1'b1;
               end
               PH_WTOKEN: begin
                  phase_in = PH_WDATA;
                  count_in = CNT_W'(1);
                  result.tx_byte  = req.payload.wr_byte;
                  result.tx_valid = 1'b1;
                  result.wr_taken = 1'b1;
               end
               PH_WDATA: begin
                  if (count_ff < {6'b0, length_ff}) begin
                     count_in = count_inc;
                     result.tx_byte  = req.payload.wr_byte;
                     result.wr_taken = 1'b1;
                  end else begin
                     phase_in = PH_WCRC;
                     count_in = CNT_W'(1);
                     result.tx_byte = BYTE_ZERO;
                  end
                  result.tx_valid = 1'b1;
               end
               PH_WCRC: begin
                  if (count_ff == CNT_W'(1)) begin
                     count_in = CNT_W'(2);
                     result.tx_byte = BYTE_ZERO;
                  end else begin
                     phase_in = PH_WRESP;
                     result.tx_byte = BYTE_FILL;
                  end
                  result.tx_valid = 1'b1;
               end
               PH_WRESP: begin
                  if (rx[3:0] != WR_ACCEPTED) begin
                     result.done_res = 1'b1;
                     result.status   = ST_WR_REJECT;
                  end else begin
                     phase_in = PH_BUSY;
                     result.tx_byte  = BYTE_FILL;
                     result.tx_valid = 1'b1;
                  end
               end
               PH_BUSY: begin
                  if (rx == BYTE_FILL) begin
                     result.done_res = 1'b1;
                  end else begin
                     result.tx_byte  = BYTE_FILL;
                     result.tx_valid = 1'b1;
                  end
               end
               default: begin
               end
            endcase
            // response complete: choose data phase
            if (after_resp) begin
               count_in = '0;
               if (length_ff == '0)  phase_in = PH_TAIL;
               else if (read_dir_ff) phase_in = PH_TOKEN;
               else                  phase_in = PH_WGAP;
               result.tx_byte  = BYTE_FILL;
               result.tx_valid = 1'b1;
            end
            // command finished: release the card
            if (result.done_res) begin
               result.response = response_in;
               phase_in  = PH_IDLE;
               select_in = 1'b0;
               count_in  = '0;
            end
         end
         result.chip_select = select_in;
      end
   end

   // two-entry output buffer, results leave in order
   always_comb begin
      head_valid_in = head_valid_ff;
      head_in       = head_ff;
      skid_valid_in = skid_valid_ff;
      skid_in       = skid_ff;
      if (rsp_xfer) begin
         if (skid_valid_ff) begin
            head_in       = skid_ff;
            skid_valid_in = 1'b0;
         end else if (req_xfer) begin
            head_in = result;
         end else begin
            head_valid_in = 1'b0;
         end
      end else if (req_xfer) begin
         if (head_valid_ff) begin
            skid_in       = result;
            skid_valid_in = 1'b1;
         end else begin
            head_in       = result;
            head_valid_in = 1'b1;
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         command_ff    <= '0;
         argument_ff   <= '0;
         length_ff     <= '0;
         read_dir_ff   <= 1'b0;
         count_ff      <= '0;
         response_ff   <= '0;
         select_ff     <= 1'b0;
         limit_ff      <= TOKEN_WAIT_RESET;
         head_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         phase_ff      <= phase_in;
         command_ff    <= command_in;
         argument_ff   <= argument_in;
         length_ff     <= length_in;
         read_dir_ff   <= read_dir_in;
         count_ff      <= count_in;
         response_ff   <= response_in;
         select_ff     <= select_in;
         limit_ff      <= limit_in;
         head_valid_ff <= head_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   // result payload registers
   always_ff @(posedge clock) begin
      head_ff <= head_in;
      skid_ff <= skid_in;
   end

   // skid entry is only used behind a waiting output entry
   a_skid_behind_head: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> head_valid_ff)
      else $error("skid entry valid while output entry empty");

   // a finished command leaves the card released and the sequencer idle
   a_done_releases: assert property (@(posedge clock) disable iff (reset)
      req_xfer && result.done_res |=> !select_ff && phase_ff == PH_IDLE)
      else $error("card still selected after command end");

   // every requested exchange happens with the card selected
   a_tx_selected: assert property (@(posedge clock) disable iff (reset)
      head_valid_ff && head_ff.tx_valid |-> head_ff.chip_select)
      else $error("byte exchange requested with card released");

   // idle sequencer never holds the card and keeps its count cleared
   a_idle_released: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_IDLE |-> !select_ff && count_ff == '0)
      else $error("idle sequencer holds card or count");

endmodule
